### rtl/fsp_pkg.sv
// Shared types, codes and helpers for the format specification parser.
package fsp_pkg;

  localparam int CNT_W              = 6;
  localparam int DEFAULT_SPEC_LIMIT = 50;
  localparam int VAL_W              = 32;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ILLEGAL  = 2'd1;
  localparam logic [1:0] STAT_TOO_LONG = 2'd2;
  localparam logic [1:0] STAT_NO_CONV  = 2'd3;

  localparam logic [1:0] LEN_NONE  = 2'd0;
  localparam logic [1:0] LEN_LONG  = 2'd1;
  localparam logic [1:0] LEN_SIZE  = 2'd2;
  localparam logic [1:0] LEN_SHORT = 2'd3;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [VAL_W-1:0] VAL_NONE     = 32'hFFFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_VARIABLE = 32'hFFFF_FFFE;

  typedef struct packed {
    logic [CNT_W-1:0] char_count;
    logic [VAL_W-1:0] accum;
    logic             seen_number;
    logic             seen_period;
    logic [VAL_W-1:0] width;
    logic             left_flag;
    logic [1:0]       length;
  } spec_state_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] field_width;
    logic signed [VAL_W-1:0] precision;
    logic                    left_adjust;
    logic [1:0]              length_mod;
    logic [7:0]              conv_char;
  } spec_result_t;

  function automatic spec_state_t reset_state();
    spec_state_t s;
    s.char_count  = CNT_W'(1);
    s.accum       = '0;
    s.seen_number = 1'b0;
    s.seen_period = 1'b0;
    s.width       = VAL_NONE;
    s.left_flag   = 1'b0;
    s.length      = LEN_NONE;
    return s;
  endfunction

  function automatic logic is_conversion(input logic [7:0] c);
    logic hit;
    unique case (c)
      "d", "i", "o", "u", "x", "X",
      "f", "e", "E", "g", "G",
      "c", "C", "s", "S", "p", "n", "r": hit = 1'b1;
      default:                           hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

### rtl/format_spec_parser.sv
// Top level of the printf-style conversion specification parser.
//
// Usage: feed the characters that follow a '%' on the input channel, one word
// per cycle (in_kind = 0, in_ch = character), or a word with in_kind = 1 to
// mark the end of the format text. A word is taken at a rising edge where
// in_valid is high and in_stall is low. Digits, '*', '.', flags and length
// letters only update the internal state and give no result. A conversion
// letter, an illegal character, reaching SPEC_LIMIT characters (the '%'
// counts as one) or the end mark each give exactly one result word on the
// out_ channel, and the parser then starts over for the next specification.
//
// Path: a taken word waits in the input register, and the decode loads the
// result register from it as the word advances; out_valid shows the result
// register.
// Throughput: one word per cycle while no result is stalled on out_stall; the
// next-state decode (a multiply by ten as shift-and-add plus a character
// decode) is combinational on the state registers, so words go back to back.
// Stall: when out_stall holds a pending result, the input register holds its
// word and in_stall rises only if that register is full; nothing is dropped.
// Reset: rst_n low (synchronous) empties both registers and returns the
// parser state to its start values.
module format_spec_parser #(
  parameter int SPEC_LIMIT = fsp_pkg::DEFAULT_SPEC_LIMIT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [7:0]                       in_ch,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic signed [fsp_pkg::VAL_W-1:0] out_field_width,
  output logic signed [fsp_pkg::VAL_W-1:0] out_precision,
  output logic                             out_left_adjust,
  output logic [1:0]                       out_length_mod,
  output logic [7:0]                       out_conv_char
);

  // input register
  logic       in_valid_r;
  logic       kind_r;
  logic [7:0] ch_r;

  // parser state
  fsp_pkg::spec_state_t state_r, state_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  fsp_pkg::spec_result_t res_r;

  logic                  advance;
  logic                  take_in;
  logic                  emit;
  fsp_pkg::spec_result_t res_dec;

  // advance the held word when the result slot is free or is drained now
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign take_in  = in_valid && !in_stall;

  fsp_decode #(
    .SPEC_LIMIT(SPEC_LIMIT)
  ) u_decode (
    .cur_state (state_r),
    .kind      (kind_r),
    .ch        (ch_r),
    .next_state(state_nxt),
    .emit      (emit),
    .result    (res_dec)
  );

  // result slot: load on an emitting word, clear once drained
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = in_valid_r && emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= fsp_pkg::reset_state();
    end else begin
      if (take_in) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
      // commit the state only for a word that actually moves on
      if (advance && in_valid_r) state_r <= state_nxt;
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (take_in) begin
      kind_r <= in_kind;
      ch_r   <= in_ch;
    end
    if (advance && in_valid_r && emit) res_r <= res_dec;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_r.status;
  assign out_field_width = res_r.field_width;
  assign out_precision   = res_r.precision;
  assign out_left_adjust = res_r.left_adjust;
  assign out_length_mod  = res_r.length_mod;
  assign out_conv_char   = res_r.conv_char;

endmodule

### rtl/fsp_decode.sv
// Per-word decode: next parser state and the optional result word.
module fsp_decode #(
  parameter int SPEC_LIMIT = fsp_pkg::DEFAULT_SPEC_LIMIT
) (
  input  fsp_pkg::spec_state_t  cur_state,
  input  logic                  kind,
  input  logic [7:0]            ch,
  output fsp_pkg::spec_state_t  next_state,
  output logic                  emit,
  output fsp_pkg::spec_result_t result
);

  localparam logic [fsp_pkg::CNT_W-1:0] LIMIT = fsp_pkg::CNT_W'(SPEC_LIMIT);

  logic [fsp_pkg::VAL_W-1:0] acc_x10;
  logic                      is_digit;

  // times ten as two shifts and an add, wrapping at 32 bits
  assign acc_x10  = {cur_state.accum[fsp_pkg::VAL_W-4:0], 3'b000}
                  + {cur_state.accum[fsp_pkg::VAL_W-2:0], 1'b0};
  assign is_digit = (ch >= "1") && (ch <= "9");

  always_comb begin
    next_state         = cur_state;
    emit               = 1'b0;
    result.status      = fsp_pkg::STAT_OK;
    result.field_width = fsp_pkg::VAL_NONE;
    result.precision   = fsp_pkg::VAL_NONE;
    result.left_adjust = 1'b0;
    result.length_mod  = fsp_pkg::LEN_NONE;
    result.conv_char   = 8'd0;
    priority if (kind == fsp_pkg::KIND_END) begin
      emit          = 1'b1;
      result.status = fsp_pkg::STAT_NO_CONV;
      next_state    = fsp_pkg::reset_state();
    end else if (cur_state.char_count >= LIMIT) begin
      emit          = 1'b1;
      result.status = fsp_pkg::STAT_TOO_LONG;
      next_state    = fsp_pkg::reset_state();
    end else if (is_digit) begin
      next_state.char_count  = cur_state.char_count + 1'b1;
      next_state.seen_number = 1'b1;
      next_state.accum       = acc_x10 + {24'd0, ch - 8'h30};
    end else if (fsp_pkg::is_conversion(ch)) begin
      emit               = 1'b1;
      result.field_width = cur_state.width;
      if (cur_state.seen_number) begin
        if (cur_state.seen_period) begin
          result.precision = cur_state.accum;
        end else begin
          result.field_width = cur_state.accum;
        end
      end
      result.left_adjust = cur_state.left_flag;
      result.length_mod  = cur_state.length;
      result.conv_char   = ch;
      next_state         = fsp_pkg::reset_state();
    end else begin
      next_state.char_count = cur_state.char_count + 1'b1;
      unique case (ch)
        "*": begin
          next_state.seen_number = 1'b1;
          next_state.accum       = fsp_pkg::VAL_VARIABLE;
        end
        "0": begin
          if (cur_state.seen_number) next_state.accum = acc_x10;
        end
        ".": begin
          next_state.seen_period = 1'b1;
          if (cur_state.seen_number) begin
            next_state.width       = cur_state.accum;
            next_state.seen_number = 1'b0;
          end
          next_state.accum = '0;
        end
        "l", "L": begin
          next_state.length = fsp_pkg::LEN_LONG;
          next_state.accum  = '0;
        end
        "z": begin
          next_state.length = fsp_pkg::LEN_SIZE;
          next_state.accum  = '0;
        end
        "h": begin
          next_state.length = fsp_pkg::LEN_SHORT;
          next_state.accum  = '0;
        end
        " ", "+", "#": begin
          next_state.accum = '0;
        end
        "-": begin
          next_state.left_flag = 1'b1;
          next_state.accum     = '0;
        end
        default: begin
          emit          = 1'b1;
          result.status = fsp_pkg::STAT_ILLEGAL;
          next_state    = fsp_pkg::reset_state();
        end
      endcase
    end
  end

endmodule

### rtl/fsp_checker.sv
// Port-level checker for the format specification parser, bound to the top.
module fsp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             in_kind,
  input logic [7:0]                       in_ch,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [1:0]                       out_status,
  input logic signed [fsp_pkg::VAL_W-1:0] out_field_width,
  input logic signed [fsp_pkg::VAL_W-1:0] out_precision,
  input logic                             out_left_adjust,
  input logic [1:0]                       out_length_mod,
  input logic [7:0]                       out_conv_char
);

  // hold a stalled input word
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_kind) && $stable(in_ch))
    else $error("stalled input word changed");

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_field_width) && $stable(out_precision)
      && $stable(out_left_adjust) && $stable(out_length_mod)
      && $stable(out_conv_char))
    else $error("stalled result word changed");

  // error results carry the fixed default fields
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != fsp_pkg::STAT_OK |->
      out_conv_char == 8'd0 && out_field_width == fsp_pkg::VAL_NONE
      && out_precision == fsp_pkg::VAL_NONE && !out_left_adjust
      && out_length_mod == fsp_pkg::LEN_NONE)
    else $error("error result with non-default fields");

  // ok results end on a conversion letter
  a_ok_conv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == fsp_pkg::STAT_OK |->
      fsp_pkg::is_conversion(out_conv_char))
    else $error("ok result without conversion letter");

  // drop everything in flight at reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("words survived reset");

endmodule

bind format_spec_parser fsp_checker u_fsp_checker (.*);
